// ===== src/rcwv_pkg.sv =====
// Shared types, register indexes, reset values and the direction window table for the wind vane reader.
`timescale 1ns / 1ps

package rcwv_pkg;

	localparam int CHARGE_BITS_DEF = 20;
	localparam int COEFF_W         = 24;
	localparam int MS_W            = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 24;
	localparam int STEP_W          = 4;
	localparam int WIN_BITS        = 18;
	localparam int BOUND_BITS      = 19;
	localparam int FRAC_BITS       = 16;
	localparam int NUM_WIN         = 16;

	localparam logic [CFG_IDX_W-1:0] REG_COEFF     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SERIES    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY     = 3'd5;

	localparam logic [COEFF_W-1:0] COEFF_RST     = 24'd641471;
	localparam logic [MS_W-1:0]    SERIES_RST    = 16'd1000;
	localparam logic [MS_W-1:0]    DISCHARGE_RST = 16'd100;
	localparam logic [MS_W-1:0]    TIMEOUT_RST   = 16'd500;
	localparam logic [MS_W-1:0]    IDLE_RST      = 16'd500;
	localparam logic [MS_W-1:0]    RETRY_RST     = 16'd1000;

	localparam logic [WIN_BITS-1:0] WIN_LO [NUM_WIN] = '{
		18'd619, 18'd801, 18'd950, 18'd1269, 18'd1980, 18'd2826, 18'd3510, 18'd5913,
		18'd7380, 18'd12708, 18'd15200, 18'd19692, 18'd29700, 18'd37908, 18'd58410,
		18'd108000
	};

	localparam logic [WIN_BITS-1:0] WIN_HI [NUM_WIN] = '{
		18'd756, 18'd935, 18'd1100, 18'd1551, 18'd2420, 18'd3454, 18'd4290, 18'd7227,
		18'd9020, 18'd14826, 18'd17600, 18'd24068, 18'd36300, 18'd46332, 18'd71390,
		18'd132000
	};

	localparam logic [STEP_W-1:0] WIN_STEP [NUM_WIN] = '{
		4'd5, 4'd3, 4'd4, 4'd7, 4'd6, 4'd9, 4'd8, 4'd1,
		4'd2, 4'd11, 4'd10, 4'd15, 4'd0, 4'd13, 4'd14, 4'd12
	};

	typedef struct packed {
		logic              hit;
		logic [STEP_W-1:0] step;
	} match_t;

endpackage

// ===== src/rc_timing_wind_vane_reader.sv =====
// A result passes the input register and then the result register before it is presented.
// One item per cycle while not stalled; the multiply and window compares sit between the registers.
// The input stage stalls only while the result register is full and stalled downstream.
// Reset: asynchronous, active low; clears the phase sequencer, counters and reading flags,
// and loads every configuration register with its default value.
`timescale 1ns / 1ps

module rc_timing_wind_vane_reader #(
	parameter int CHARGE_BITS = rcwv_pkg::CHARGE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rcwv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcwv_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            us_tick,
	input  logic                            ms_tick,
	input  logic                            capture_edge,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            trig_level,
	output logic                            capture_armed,
	output logic [rcwv_pkg::STEP_W-1:0]     direction_step,
	output logic                            reading_valid,
	output logic                            error_flag,
	output logic                            new_reading
);

	typedef enum logic [2:0] {
		PH_START     = 3'd0,
		PH_DISCHARGE = 3'd1,
		PH_WAIT_EDGE = 3'd2,
		PH_IDLE      = 3'd3,
		PH_ERROR     = 3'd4,
		PH_RETRY     = 3'd5
	} phase_t;

	logic [rcwv_pkg::COEFF_W-1:0] coeff_q;
	logic [rcwv_pkg::MS_W-1:0]    series_q;
	logic [rcwv_pkg::MS_W-1:0]    discharge_q;
	logic [rcwv_pkg::MS_W-1:0]    timeout_q;
	logic [rcwv_pkg::MS_W-1:0]    idle_q;
	logic [rcwv_pkg::MS_W-1:0]    retry_q;

	logic valid_s1;
	logic us_s1;
	logic ms_s1;
	logic edge_s1;

	phase_t                       phase_q;
	logic [rcwv_pkg::MS_W-1:0]    phase_ms_q;
	logic [CHARGE_BITS-1:0]       charge_us_q;
	logic [rcwv_pkg::STEP_W-1:0]  dir_q;
	logic                         valid_reg_q;
	logic                         err_q;

	phase_t                       phase_d;
	logic [rcwv_pkg::MS_W-1:0]    phase_ms_d;
	logic [CHARGE_BITS-1:0]       charge_us_d;
	logic [rcwv_pkg::STEP_W-1:0]  dir_d;
	logic                         valid_reg_d;
	logic                         err_d;
	logic                         fresh_d;

	logic [rcwv_pkg::MS_W-1:0]    ms_cnt;
	logic                         advance;
	rcwv_pkg::match_t             match;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q     <= rcwv_pkg::COEFF_RST;
			series_q    <= rcwv_pkg::SERIES_RST;
			discharge_q <= rcwv_pkg::DISCHARGE_RST;
			timeout_q   <= rcwv_pkg::TIMEOUT_RST;
			idle_q      <= rcwv_pkg::IDLE_RST;
			retry_q     <= rcwv_pkg::RETRY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rcwv_pkg::REG_COEFF:     coeff_q     <= cfg_data;
				rcwv_pkg::REG_SERIES:    series_q    <= cfg_data[rcwv_pkg::MS_W-1:0];
				rcwv_pkg::REG_DISCHARGE: discharge_q <= cfg_data[rcwv_pkg::MS_W-1:0];
				rcwv_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data[rcwv_pkg::MS_W-1:0];
				rcwv_pkg::REG_IDLE:      idle_q      <= cfg_data[rcwv_pkg::MS_W-1:0];
				rcwv_pkg::REG_RETRY:     retry_q     <= cfg_data[rcwv_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			us_s1   <= us_tick;
			ms_s1   <= ms_tick;
			edge_s1 <= capture_edge;
		end
	end

	rcwv_window_match #(
		.CHARGE_BITS(CHARGE_BITS)
	) u_match (
		.charge_us  (charge_us_q),
		.coeff_q16  (coeff_q),
		.series_ohms(series_q),
		.match      (match)
	);

	assign ms_cnt = (ms_s1 && phase_ms_q != {rcwv_pkg::MS_W{1'b1}})
		? phase_ms_q + rcwv_pkg::MS_W'(1) : phase_ms_q;

	always_comb begin
		phase_d     = phase_q;
		phase_ms_d  = phase_ms_q;
		charge_us_d = charge_us_q;
		dir_d       = dir_q;
		valid_reg_d = valid_reg_q;
		err_d       = err_q;
		fresh_d     = 1'b0;
		case (phase_q)
			PH_START: begin
				phase_ms_d = '0;
				phase_d    = PH_DISCHARGE;
			end
			PH_DISCHARGE: begin
				phase_ms_d = ms_cnt;
				if (ms_cnt >= discharge_q) begin
					charge_us_d = '0;
					phase_ms_d  = '0;
					phase_d     = PH_WAIT_EDGE;
				end
			end
			PH_WAIT_EDGE: begin
				if (edge_s1) begin
					phase_ms_d = '0;
					if (match.hit) begin
						dir_d       = match.step;
						valid_reg_d = 1'b1;
						err_d       = 1'b0;
						fresh_d     = 1'b1;
						phase_d     = PH_IDLE;
					end else begin
						phase_d = PH_ERROR;
					end
				end else begin
					if (us_s1 && charge_us_q != {CHARGE_BITS{1'b1}}) begin
						charge_us_d = charge_us_q + CHARGE_BITS'(1);
					end
					phase_ms_d = ms_cnt;
					if (ms_cnt >= timeout_q) begin
						phase_ms_d = '0;
						phase_d    = PH_ERROR;
					end
				end
			end
			PH_IDLE: begin
				phase_ms_d = ms_cnt;
				if (ms_cnt >= idle_q) begin
					phase_d = PH_START;
				end
			end
			PH_ERROR: begin
				err_d       = 1'b1;
				valid_reg_d = 1'b0;
				phase_ms_d  = '0;
				phase_d     = PH_RETRY;
			end
			PH_RETRY: begin
				phase_ms_d = ms_cnt;
				if (ms_cnt >= retry_q) begin
					phase_d = PH_START;
				end
			end
			default: begin
				phase_ms_d = '0;
				phase_d    = PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_START;
			phase_ms_q     <= '0;
			charge_us_q    <= '0;
			dir_q          <= '0;
			valid_reg_q    <= 1'b0;
			err_q          <= 1'b0;
			out_valid      <= 1'b0;
			trig_level     <= 1'b0;
			capture_armed  <= 1'b0;
			direction_step <= '0;
			reading_valid  <= 1'b0;
			error_flag     <= 1'b0;
			new_reading    <= 1'b0;
		end else begin
			if (advance) begin
				phase_q        <= phase_d;
				phase_ms_q     <= phase_ms_d;
				charge_us_q    <= charge_us_d;
				dir_q          <= dir_d;
				valid_reg_q    <= valid_reg_d;
				err_q          <= err_d;
				out_valid      <= 1'b1;
				trig_level     <= (phase_d == PH_START) || (phase_d == PH_DISCHARGE);
				capture_armed  <= (phase_d == PH_WAIT_EDGE);
				direction_step <= dir_d;
				reading_valid  <= valid_reg_d;
				error_flag     <= err_d;
				new_reading    <= fresh_d;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_fresh_is_good: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_reading |-> reading_valid && !error_flag)
		else $error("New reading reported without a valid, error-free state.");

	a_armed_not_trig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && capture_armed |-> !trig_level && !new_reading)
		else $error("Capture armed while the trigger drives discharge or a reading completes.");

	a_error_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_flag |-> !reading_valid)
		else $error("Error and valid reading reported together.");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("Input stalled without a held item and a stalled result.");

endmodule

// ===== src/rcwv_window_match.sv =====
// Charge time to resistance conversion and first-match search over the direction windows.
`timescale 1ns / 1ps

module rcwv_window_match #(
	parameter int CHARGE_BITS = rcwv_pkg::CHARGE_BITS_DEF
) (
	input  logic [CHARGE_BITS-1:0]       charge_us,
	input  logic [rcwv_pkg::COEFF_W-1:0] coeff_q16,
	input  logic [rcwv_pkg::MS_W-1:0]    series_ohms,
	output rcwv_pkg::match_t             match
);

	localparam int PW = CHARGE_BITS + rcwv_pkg::COEFF_W;

	logic [PW-1:0] prod;

	assign prod = PW'(charge_us) * PW'(coeff_q16);

	// Windows are scanned from the end so that the earliest table entry wins.
	always_comb begin
		logic [rcwv_pkg::BOUND_BITS-1:0] lo_b;
		logic [rcwv_pkg::BOUND_BITS-1:0] hi_b;
		logic [PW-1:0] lo_p;
		logic [PW-1:0] hi_p;
		match = '0;
		for (int i = rcwv_pkg::NUM_WIN - 1; i >= 0; i--) begin
			lo_b = rcwv_pkg::BOUND_BITS'(rcwv_pkg::WIN_LO[i])
				+ rcwv_pkg::BOUND_BITS'(series_ohms);
			hi_b = rcwv_pkg::BOUND_BITS'(rcwv_pkg::WIN_HI[i])
				+ rcwv_pkg::BOUND_BITS'(series_ohms);
			lo_p = PW'({lo_b, {rcwv_pkg::FRAC_BITS{1'b0}}});
			hi_p = PW'({hi_b, {rcwv_pkg::FRAC_BITS{1'b0}}});
			if (prod >= lo_p && prod <= hi_p) begin
				match.hit  = 1'b1;
				match.step = rcwv_pkg::WIN_STEP[i];
			end
		end
	end

endmodule

// ===== tb/tb_rc_timing_wind_vane_reader.sv =====
// Testbench for the wind vane reader: drives tick and capture transfers, predicts each reading and checks it.
`timescale 1ns / 1ps

typedef enum logic [2:0] {
	CAP_START     = 3'd0,
	CAP_DISCHARGE = 3'd1,
	CAP_WAIT      = 3'd2,
	CAP_IDLE      = 3'd3,
	CAP_ERROR     = 3'd4,
	CAP_RETRY     = 3'd5
} vane_phase_t;

typedef struct packed {
	logic       trig;
	logic       armed;
	logic [3:0] step;
	logic       rvalid;
	logic       err;
	logic       fresh;
} vane_reading_t;

localparam bit [0:15][17:0] OHMS_LO = {
	18'd619, 18'd801, 18'd950, 18'd1269, 18'd1980, 18'd2826, 18'd3510, 18'd5913,
	18'd7380, 18'd12708, 18'd15200, 18'd19692, 18'd29700, 18'd37908, 18'd58410, 18'd108000
};
localparam bit [0:15][17:0] OHMS_HI = {
	18'd756, 18'd935, 18'd1100, 18'd1551, 18'd2420, 18'd3454, 18'd4290, 18'd7227,
	18'd9020, 18'd14826, 18'd17600, 18'd24068, 18'd36300, 18'd46332, 18'd71390, 18'd132000
};
localparam bit [0:15][3:0] OHMS_STEP = {
	4'd5, 4'd3, 4'd4, 4'd7, 4'd6, 4'd9, 4'd8, 4'd1,
	4'd2, 4'd11, 4'd10, 4'd15, 4'd0, 4'd13, 4'd14, 4'd12
};

class vane_reading_board #(parameter int CHARGE_W = 16);
	vane_phase_t         phase;
	logic [15:0]         phase_ms;
	logic [CHARGE_W-1:0] charge;
	logic [23:0]         coeff;
	logic [15:0]         series;
	logic [15:0]         discharge_len;
	logic [15:0]         timeout_len;
	logic [15:0]         idle_len;
	logic [15:0]         retry_len;
	logic [3:0]          direction;
	logic                valid_seen;
	logic                error_seen;
	vane_reading_t       pending[$];
	int                  mismatches;
	int                  readings;

	function new();
		phase = CAP_START;
		phase_ms = '0;
		charge = '0;
		direction = '0;
		valid_seen = 1'b0;
		error_seen = 1'b0;
		coeff = rcwv_pkg::COEFF_RST;
		series = rcwv_pkg::SERIES_RST;
		discharge_len = rcwv_pkg::DISCHARGE_RST;
		timeout_len = rcwv_pkg::TIMEOUT_RST;
		idle_len = rcwv_pkg::IDLE_RST;
		retry_len = rcwv_pkg::RETRY_RST;
		mismatches = 0;
		readings = 0;
	endfunction

	function void set_reg(logic [rcwv_pkg::CFG_IDX_W-1:0] idx, logic [23:0] data);
		case (idx)
			rcwv_pkg::REG_COEFF: coeff = data;
			rcwv_pkg::REG_SERIES: series = data[15:0];
			rcwv_pkg::REG_DISCHARGE: discharge_len = data[15:0];
			rcwv_pkg::REG_TIMEOUT: timeout_len = data[15:0];
			rcwv_pkg::REG_IDLE: idle_len = data[15:0];
			rcwv_pkg::REG_RETRY: retry_len = data[15:0];
			default: ;
		endcase
	endfunction

	// A millisecond tick advances the phase timer, which holds at its top value.
	function bit ms_elapsed(bit ms, logic [15:0] len);
		if (ms && phase_ms != 16'hFFFF)
			phase_ms++;
		return phase_ms >= len;
	endfunction

	function bit find_step(output logic [3:0] step);
		logic [63:0] prod;
		logic [63:0] lo;
		logic [63:0] hi;
		prod = 64'(charge) * 64'(coeff);
		step = '0;
		for (int i = 0; i < 16; i++) begin
			lo = (64'(OHMS_LO[i]) + 64'(series)) << 16;
			hi = (64'(OHMS_HI[i]) + 64'(series)) << 16;
			if (prod >= lo && prod <= hi) begin
				step = OHMS_STEP[i];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function void take_sample(bit us, bit ms, bit cap);
		vane_reading_t want;
		logic [3:0]    step;
		bit            fresh;
		fresh = 1'b0;
		case (phase)
			CAP_START: begin
				phase_ms = '0;
				phase = CAP_DISCHARGE;
			end
			CAP_DISCHARGE: begin
				if (ms_elapsed(ms, discharge_len)) begin
					charge = '0;
					phase_ms = '0;
					phase = CAP_WAIT;
				end
			end
			CAP_WAIT: begin
				if (cap) begin
					phase_ms = '0;
					if (find_step(step)) begin
						direction = step;
						valid_seen = 1'b1;
						error_seen = 1'b0;
						fresh = 1'b1;
						phase = CAP_IDLE;
					end else begin
						phase = CAP_ERROR;
					end
				end else begin
					if (us && charge != '1)
						charge++;
					if (ms_elapsed(ms, timeout_len)) begin
						phase_ms = '0;
						phase = CAP_ERROR;
					end
				end
			end
			CAP_IDLE: begin
				if (ms_elapsed(ms, idle_len))
					phase = CAP_START;
			end
			CAP_ERROR: begin
				error_seen = 1'b1;
				valid_seen = 1'b0;
				phase_ms = '0;
				phase = CAP_RETRY;
			end
			CAP_RETRY: begin
				if (ms_elapsed(ms, retry_len))
					phase = CAP_START;
			end
			default: begin
				phase_ms = '0;
				phase = CAP_START;
			end
		endcase
		want.trig = (phase == CAP_START || phase == CAP_DISCHARGE);
		want.armed = (phase == CAP_WAIT);
		want.step = direction;
		want.rvalid = valid_seen;
		want.err = error_seen;
		want.fresh = fresh;
		pending.push_back(want);
	endfunction

	function void report(string what, vane_reading_t want, vane_reading_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$write("%s at reading %0d: expected trig=%b armed=%b step=%0d valid=%b err=%b ",
				what, readings, want.trig, want.armed, want.step, want.rvalid, want.err);
			$display("new=%b, got trig=%b armed=%b step=%0d valid=%b err=%b new=%b",
				want.fresh, got.trig, got.armed, got.step, got.rvalid, got.err, got.fresh);
		end
	endfunction

	function void compare_reading(vane_reading_t got);
		vane_reading_t want;
		readings++;
		if (pending.size() == 0) begin
			report("Unexpected transfer", '0, got);
			return;
		end
		want = pending.pop_front();
		if (got.trig !== want.trig || got.armed !== want.armed || got.step !== want.step ||
				got.rvalid !== want.rvalid || got.err !== want.err || got.fresh !== want.fresh)
			report("Wrong reading", want, got);
	endfunction
endclass

module tb_rc_timing_wind_vane_reader;
	localparam int CHARGE_W = rcwv_pkg::CHARGE_BITS_DEF;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int HOLD_CYCLES = 150;
	localparam logic [rcwv_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	// Opening sequence, one {us_tick, ms_tick, capture_edge} per transfer.
	localparam bit [0:22][2:0] OPENING = {
		3'b101, 3'b111, 3'b100, 3'b100, 3'b100, 3'b101, 3'b000, 3'b010,
		3'b000, 3'b010, 3'b110, 3'b110, 3'b100, 3'b100, 3'b011, 3'b010,
		3'b000, 3'b010, 3'b110, 3'b110, 3'b110, 3'b000, 3'b010
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rcwv_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rcwv_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic us_tick;
	logic ms_tick;
	logic capture_edge;
	logic out_valid;
	logic out_stall;
	logic trig_level;
	logic capture_armed;
	logic [rcwv_pkg::STEP_W-1:0] direction_step;
	logic reading_valid;
	logic error_flag;
	logic new_reading;

	vane_reading_board #(CHARGE_W) board;
	bit quiet;
	bit hold_request;
	bit planned;
	bit noisy;
	bit give_up;
	longint unsigned target;

	rc_timing_wind_vane_reader #(.CHARGE_BITS(CHARGE_W)) dut (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("rc_timing_wind_vane_reader: mismatch");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_readings
		vane_reading_t got;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			got = {trig_level, capture_armed, direction_step, reading_valid, error_flag,
				new_reading};
			board.compare_reading(got);
		end
	end

	task automatic send_item(input bit us, input bit ms, input bit cap);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		us_tick <= us;
		ms_tick <= ms;
		capture_edge <= cap;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.take_sample(us, ms, cap);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rcwv_pkg::CFG_IDX_W-1:0] idx, input logic [23:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, data);
	endtask

	task automatic configure(input logic [23:0] coeff, input logic [15:0] series,
			input logic [15:0] dis, input logic [15:0] tmo, input logic [15:0] idle,
			input logic [15:0] retry);
		wait_drained();
		write_reg(rcwv_pkg::REG_COEFF, coeff);
		write_reg(rcwv_pkg::REG_SERIES, {8'd0, series});
		write_reg(rcwv_pkg::REG_DISCHARGE, {8'd0, dis});
		write_reg(rcwv_pkg::REG_TIMEOUT, {8'd0, tmo});
		write_reg(rcwv_pkg::REG_IDLE, {8'd0, idle});
		write_reg(rcwv_pkg::REG_RETRY, {8'd0, retry});
	endtask

	// Most charge periods aim at a window edge or its inside; the rest time out or are noise.
	task automatic random_item();
		longint unsigned lo_t;
		longint unsigned hi_t;
		int w;
		bit us;
		bit ms;
		bit cap;
		if (board.phase == CAP_WAIT) begin
			if (!planned) begin
				planned = 1'b1;
				w = $urandom_range(0, 9);
				noisy = (w == 0);
				give_up = (w == 1);
				target = 64'($urandom_range(0, 300));
				if (board.coeff != 0) begin
					for (int tries = 0; tries < 8; tries++) begin
						w = $urandom_range(0, 15);
						lo_t = (((64'(OHMS_LO[w]) + 64'(board.series)) << 16) + 64'(board.coeff) - 1)
							/ 64'(board.coeff);
						hi_t = ((64'(OHMS_HI[w]) + 64'(board.series)) << 16) / 64'(board.coeff);
						if (lo_t <= hi_t && lo_t <= 700) begin
							case ($urandom_range(0, 5))
								0: target = (lo_t > 0) ? lo_t - 1 : 0;
								1: target = hi_t + 1;
								2: target = lo_t;
								3: target = hi_t;
								default: target = 64'($urandom_range(32'(lo_t),
									32'((hi_t < 700) ? hi_t : 700)));
							endcase
							if (target > 900)
								target = lo_t;
							break;
						end
					end
				end
			end
			if (noisy) begin
				us = 1'($urandom_range(0, 1));
				ms = 1'($urandom_range(0, 1));
				cap = ($urandom_range(0, 7) == 0);
			end else if (give_up) begin
				us = 1'($urandom_range(0, 1));
				ms = ($urandom_range(0, 3) != 0);
				cap = 1'b0;
			end else if (board.charge >= target) begin
				us = 1'($urandom_range(0, 1));
				ms = ($urandom_range(0, 7) == 0);
				cap = 1'b1;
			end else begin
				us = ($urandom_range(0, 9) != 0);
				ms = 1'b0;
				cap = 1'b0;
			end
		end else begin
			planned = 1'b0;
			us = 1'($urandom_range(0, 1));
			ms = ($urandom_range(0, 3) != 0);
			cap = ($urandom_range(0, 3) == 0);
		end
		send_item(us, ms, cap);
	endtask

	initial begin
		logic [23:0] coeff;
		logic [15:0] series;
		logic [15:0] dis;
		logic [15:0] tmo;
		logic [15:0] idle;
		logic [15:0] retry;
		int count;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		us_tick = 1'b0;
		ms_tick = 1'b0;
		capture_edge = 1'b0;
		quiet = 1'b0;
		hold_request = 1'b0;
		planned = 1'b0;
		noisy = 1'b0;
		give_up = 1'b0;
		target = 0;
		board = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_UNUSED, 24'($urandom));
		configure(24'hFFFFFF, 16'd0, 16'd1, 16'd3, 16'd1, 16'd1);
		for (int i = 0; i < 23; i++)
			send_item(OPENING[i][2], OPENING[i][1], OPENING[i][0]);
		drop_valid();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin
					coeff = 24'd641471; series = 16'd1000;
					dis = 16'd1; tmo = 16'd40; idle = 16'd1; retry = 16'd1;
				end
				2: begin
					coeff = 24'hFFFFFF; series = 16'd0;
					dis = 16'd0; tmo = 16'd2; idle = 16'd0; retry = 16'd0;
				end
				3: begin
					coeff = 24'd0; series = 16'hFFFF;
					dis = 16'd1; tmo = 16'd4; idle = 16'd1; retry = 16'd1;
				end
				4: begin
					coeff = 24'hFFFFFF; series = 16'hFFFF;
					dis = 16'd2; tmo = 16'd30; idle = 16'd2; retry = 16'd2;
				end
				6: begin
					coeff = 24'd1; series = 16'd1;
					dis = 16'hFFFF; tmo = 16'hFFFF; idle = 16'hFFFF; retry = 16'hFFFF;
				end
				default: begin
					coeff = 24'($urandom_range(1 << 20, 24'hFFFFFF));
					series = 16'($urandom_range(0, 3000));
					dis = 16'($urandom_range(1, 3));
					tmo = 16'($urandom_range(2, 60));
					idle = 16'($urandom_range(1, 3));
					retry = 16'($urandom_range(1, 3));
				end
			endcase
			configure(coeff, series, dis, tmo, idle, retry);
			quiet = (ph == 8);
			count = (ph == 6) ? 40 : 170;
			for (int k = 0; k < count; k++) begin
				if (ph == 5 && k == 60)
					hold_request = 1'b1;
				random_item();
			end
			drop_valid();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("rc_timing_wind_vane_reader: match");
		else
			$display("rc_timing_wind_vane_reader: mismatch");
		$finish;
	end
endmodule
